>>> rtl/aes_pkg.sv
// Shared types, constants and round functions for the AES block encryptor.
package aes_pkg;

    localparam int NR_MAX = 14;
    localparam int NK_MAX = 8;

    typedef enum logic [1:0] {
        KL_128 = 2'd0,
        KL_192 = 2'd1,
        KL_256 = 2'd2,
        KL_RSV = 2'd3
    } t_key_len;

    typedef enum logic [2:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_KEY_PART_0 = 3'd1,
        REG_KEY_PART_1 = 3'd2,
        REG_KEY_PART_2 = 3'd3,
        REG_KEY_PART_3 = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KX_LOAD,
        KX_RUN,
        KX_DONE
    } t_kx_state;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        is_last;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        last_out;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

    typedef logic [NR_MAX:0][127:0] t_rk_bank;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte b of the state sits at bits [127-8b -: 8]; byte 4c+r is row r of column c.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

>>> rtl/aes_keyexp.sv
// Iterative AES key expansion, one schedule word per cycle, into a round key bank.
module aes_keyexp import aes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_reload,
    input  t_key_len         i_key_len,
    input  logic [3:0][63:0] i_key_part,
    output t_rk_bank         o_rk,
    output logic             o_busy
);

    t_kx_state                    r_state, n_state;
    logic [5:0]                   r_idx, n_idx;
    logic [2:0]                   r_mod, n_mod;
    logic [7:0]                   r_rcon, n_rcon;
    logic [NK_MAX-1:0][31:0]      r_hist, n_hist;
    logic [NR_MAX:0][3:0][31:0]   r_rk, n_rk;

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [2:0]  nk_m1;
    logic [31:0] key_word [NK_MAX];
    logic [31:0] tmp;
    logic [31:0] new_word;
    logic [2:0]  src;

    always_comb begin
        unique case (i_key_len)
            KL_192:  begin nk = 4'd6; last_idx = 6'd51; end
            KL_256:  begin nk = 4'd8; last_idx = 6'd59; end
            default: begin nk = 4'd4; last_idx = 6'd43; end
        endcase
        nk_m1 = 3'(nk - 4'd1);
    end

    always_comb begin
        for (int k = 0; k < NK_MAX; k++) begin
            key_word[k] = (k % 2 == 0) ? i_key_part[k / 2][63:32] : i_key_part[k / 2][31:0];
        end
    end

    always_comb begin
        if (r_mod == 3'd0) begin
            tmp = sub_word({r_hist[0][23:0], r_hist[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_mod == 3'd4) begin
            tmp = sub_word(r_hist[0]);
        end else begin
            tmp = r_hist[0];
        end
        new_word = r_hist[nk_m1] ^ tmp;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_mod   = r_mod;
        n_rcon  = r_rcon;
        n_hist  = r_hist;
        n_rk    = r_rk;
        src     = 3'd0;
        unique case (r_state)
            KX_LOAD: begin
                for (int k = 0; k < NK_MAX; k++) begin
                    n_rk[k / 4][3 - (k % 4)] = key_word[k];
                    src = 3'(nk_m1 - 3'(k));
                    n_hist[k] = key_word[src];
                end
                n_idx   = {2'b00, nk};
                n_mod   = 3'd0;
                n_rcon  = 8'h01;
                n_state = KX_RUN;
            end
            KX_RUN: begin
                n_rk[r_idx[5:2]][2'd3 - r_idx[1:0]] = new_word;
                n_hist = {r_hist[NK_MAX-2:0], new_word};
                if (r_mod == 3'd0) begin
                    n_rcon = xtime(r_rcon);
                end
                n_mod = (r_mod == nk_m1) ? 3'd0 : 3'(r_mod + 3'd1);
                n_idx = 6'(r_idx + 6'd1);
                if (r_idx == last_idx) begin
                    n_state = KX_DONE;
                end
            end
            default: begin
                n_state = KX_DONE;
            end
        endcase
        if (i_reload) begin
            n_state = KX_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KX_LOAD;
            r_idx   <= '0;
            r_mod   <= '0;
            r_rcon  <= 8'h01;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_mod   <= n_mod;
            r_rcon  <= n_rcon;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist <= n_hist;
        r_rk   <= n_rk;
    end

    always_comb begin
        for (int r = 0; r <= NR_MAX; r++) begin
            o_rk[r] = r_rk[r];
        end
    end

    assign o_busy = (r_state != KX_DONE) || i_reload;

endmodule

>>> rtl/aes_round.sv
// One registered AES round stage; full round, final round or pass-through by round number.
module aes_round import aes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [3:0]   i_round,
    input  logic [3:0]   i_nr,
    input  t_stage_ctl   i_ctl,
    input  logic [127:0] i_state,
    input  logic [127:0] i_rk,
    output t_stage_ctl   o_ctl,
    output logic [127:0] o_state
);

    t_stage_ctl   r_ctl;
    logic [127:0] r_state, n_state;
    logic [127:0] sub;

    always_comb begin
        sub = sub_shift(i_state);
        if (i_round > i_nr) begin
            n_state = i_state;
        end else if (i_round == i_nr) begin
            n_state = sub ^ i_rk;
        end else begin
            n_state = mix_columns(sub) ^ i_rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule

>>> rtl/aes_block_encryptor.sv
// AES-128/192/256 ECB encryptor: key schedule unit and a fourteen-stage round pipeline.
// An accepted beat passes stage zero and the round stages to o_result with o_valid.
// Throughput: one beat per cycle when not busy; each round is a stage with one S-box layer.
// Shorter keys pass their unused final stages straight through, so every key length has the same latency.
// After reset and after any configuration write the key schedule is rebuilt one word per
// cycle; busy stays high meanwhile.
module aes_block_encryptor import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_beat    i_block,
    output logic        o_valid,
    output t_out_beat   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers. Bytes past the selected key size are ignored
    // by the key schedule, and the unused length code runs as a 128-bit key.
    t_key_len         r_key_len;
    logic [3:0][63:0] r_key_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= KL_128;
            r_key_part <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_LENGTH: r_key_len     <= t_key_len'(i_cfg_data[1:0]);
                REG_KEY_PART_0: r_key_part[0] <= i_cfg_data;
                REG_KEY_PART_1: r_key_part[1] <= i_cfg_data;
                REG_KEY_PART_2: r_key_part[2] <= i_cfg_data;
                REG_KEY_PART_3: r_key_part[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The schedule restarts on every write; the block is idle then by contract.
    t_rk_bank rk;
    logic     kx_busy;

    aes_keyexp u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reload   (i_cfg_we),
        .i_key_len  (r_key_len),
        .i_key_part (r_key_part),
        .o_rk       (rk),
        .o_busy     (kx_busy)
    );

    assign busy = kx_busy;

    logic [3:0] nr;
    always_comb begin
        unique case (r_key_len)
            KL_192:  nr = 4'd12;
            KL_256:  nr = 4'd14;
            default: nr = 4'd10;
        endcase
    end

    // Stage zero applies the initial round key as the beat is taken in.
    t_stage_ctl   r_ctl0;
    logic [127:0] r_state0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0.valid <= start && !busy;
            r_ctl0.last  <= i_block.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state0 <= {i_block.block_high, i_block.block_low} ^ rk[0];
    end

    // Round stages; valid and the end-of-stream mark travel with each block.
    t_stage_ctl   ctl   [NR_MAX+1];
    logic [127:0] state [NR_MAX+1];

    assign ctl[0]   = r_ctl0;
    assign state[0] = r_state0;

    for (genvar g = 1; g <= NR_MAX; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (4'(g)),
            .i_nr    (nr),
            .i_ctl   (ctl[g-1]),
            .i_state (state[g-1]),
            .i_rk    (rk[g]),
            .o_ctl   (ctl[g]),
            .o_state (state[g])
        );
    end

    assign o_valid              = ctl[NR_MAX].valid;
    assign o_result.cipher_high = state[NR_MAX][127:64];
    assign o_result.cipher_low  = state[NR_MAX][63:0];
    assign o_result.last_out    = ctl[NR_MAX].last;

endmodule

>>> test/aes_block_encryptor_tb.sv
// Self-checking testbench for the AES ECB block encryptor, with its own cipher predictor.
module aes_block_encryptor_tb;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    // Results land once a block has passed the whole pipe; allow some margin at the end.
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_beat    i_block;
    logic        o_valid;
    t_out_beat   o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    aes_block_encryptor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_block    (i_block),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // The predictor keeps its own copy of the key registers.
    logic [1:0]  key_len_q;
    logic [63:0] key_q [4];

    t_out_beat   cipher_fifo [$];
    int          mismatches;
    int          cycle_count;
    int          sender_idle_pct;

    // S-box values, kept locally so the predictor does not lean on the package table.
    logic [7:0] sbox_lut [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    // Full FIPS-197 encryption of one block under the current key registers.
    function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
        logic [31:0]  w [60];
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [31:0]  t;
        logic [7:0]   rcon;
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] res;
        int           nk, nr;
        nk = (key_len_q == KL_192) ? 6 : (key_len_q == KL_256) ? 8 : 4;
        nr = nk + 6;
        rcon = 8'h01;
        for (int i = 0; i < nk; i++) begin
            w[i] = (i & 1) ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
        end
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end else if (nk == 8 && i % nk == 4) begin
                t = sbox_word(t);
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int b = 0; b < 16; b++) st[b] = plain[127 - 8 * b -: 8];
        for (int rnd = 0; rnd <= nr; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4 * c + r] = sbox_lut[st[4 * ((c + r) % 4) + r]];
                st = tmp;
                if (rnd < nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4 * c]; a1 = st[4 * c + 1];
                        a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        st[4 * c]     = a0 ^ al ^ gf_double(a0 ^ a1);
                        st[4 * c + 1] = a1 ^ al ^ gf_double(a1 ^ a2);
                        st[4 * c + 2] = a2 ^ al ^ gf_double(a2 ^ a3);
                        st[4 * c + 3] = a3 ^ al ^ gf_double(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4 * c + r] ^= w[4 * rnd + c][31 - 8 * r -: 8];
        end
        for (int b = 0; b < 16; b++) res[127 - 8 * b -: 8] = st[b];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Global watchdog: the run must end well before this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result checker. The block cannot be held off, so every strobe is one beat.
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_valid) begin
            if (cipher_fifo.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("ERROR: unexpected result beat %h", o_result);
            end else begin
                exp_beat = cipher_fifo.pop_front();
                if (o_result !== exp_beat) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("ERROR: expected %h_%h last %b, got %h_%h last %b",
                                 exp_beat.cipher_high, exp_beat.cipher_low, exp_beat.last_out,
                                 o_result.cipher_high, o_result.cipher_low, o_result.last_out);
                end
            end
        end
    end

    // Write one key register, mirroring it into the predictor. The caller drops the
    // write enable after its last write.
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == REG_KEY_LENGTH) key_len_q = data[1:0];
        else if (idx <= REG_KEY_PART_3) key_q[idx - 1] = data;
    endtask

    task automatic load_key(input logic [1:0] kl, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(REG_KEY_LENGTH, {62'd0, kl});
        write_reg(REG_KEY_PART_0, k0);
        write_reg(REG_KEY_PART_1, k1);
        write_reg(REG_KEY_PART_2, k2);
        write_reg(REG_KEY_PART_3, k3);
        i_cfg_we <= 1'b0;
    endtask

    // Stop offering blocks, wait until every expected beat has come out, then let
    // the pipe drain.
    task automatic wait_idle();
        start <= 1'b0;
        while (cipher_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one block and hold it until the block takes it. If check_exp is set, the
    // typed-in ciphertext is queued; otherwise the predictor supplies it. Busy is
    // sampled at the falling edge, so the rising edge that follows a low busy is the
    // accepting one. Start stays high afterwards so that blocks can follow back to back.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic last,
                              input logic check_exp, input logic [127:0] exp_ct);
        t_out_beat eb;
        logic [127:0] ct;
        while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_block <= '{block_high: hi, block_low: lo, is_last: last};
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        ct = check_exp ? exp_ct : encrypt_block({hi, lo});
        eb = '{cipher_high: ct[127:64], cipher_low: ct[63:0], last_out: last};
        cipher_fifo.push_back(eb);
    endtask

    typedef struct {
        logic [1:0]   kl;
        logic [63:0]  k [4];
        logic [63:0]  hi;
        logic [63:0]  lo;
        logic         last;
        logic         known;
        logic [127:0] ct;
    } t_dir_row;

    // Directed rows: standard test vectors, the all-zero key after reset, extremes,
    // the unused key length code, and junk in key parts beyond the selected size.
    t_dir_row dir_rows [] = '{
        '{KL_128, '{64'h0, 64'h0, 64'h0, 64'h0}, 64'h0, 64'h0, 1'b0, 1'b1,
          128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{KL_128, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0},
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{KL_192, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, 64'h0},
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b1,
          128'hdda97ca4864cdfe06eaf70a0ec0d7191},
        '{KL_256, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                    64'h18191a1b1c1d1e1f},
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
          128'h8ea2b7ca516745bfeafc49904b496089},
        '{KL_128, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'hdeadbeefdeadbeef,
                    64'hffffffffffffffff},
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{KL_RSV, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1234, 64'h5678},
          64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
          128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{KL_128, '{'1, '1, '1, '1}, '1, '1, 1'b1, 1'b0, 128'h0},
        '{KL_192, '{'1, '1, '1, '1}, '1, '1, 1'b0, 1'b0, 128'h0},
        '{KL_256, '{'1, '1, '1, '1}, '1, '1, 1'b1, 1'b0, 128'h0},
        '{KL_256, '{'0, '0, '0, '0}, '1, '0, 1'b0, 1'b0, 128'h0},
        '{KL_192, '{64'h8000000000000001, '0, 64'h0123456789abcdef, '1},
          '0, '1, 1'b1, 1'b0, 128'h0}
    };

    initial begin
        logic [1:0]  kl;
        int          blocks;
        cycle_count     = 0;
        mismatches      = 0;
        sender_idle_pct = 0;
        key_len_q       = KL_128;
        for (int i = 0; i < 4; i++) key_q[i] = '0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_block    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_KEY_LENGTH;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The first row runs on the reset key, before any write.
        foreach (dir_rows[n]) begin
            if (n > 0) begin
                wait_idle();
                load_key(dir_rows[n].kl, dir_rows[n].k[0], dir_rows[n].k[1],
                         dir_rows[n].k[2], dir_rows[n].k[3]);
            end
            send_block(dir_rows[n].hi, dir_rows[n].lo, dir_rows[n].last,
                       dir_rows[n].known, dir_rows[n].ct);
        end

        // Random part: new keys each phase, idling mix cycles through the phases.
        for (int ph = 0; ph < 16; ph++) begin
            wait_idle();
            kl = (ph % 8 == 7) ? KL_RSV : 2'(ph % 3);
            load_key(kl, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            case (ph % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 61;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 25;
            endcase
            blocks = $urandom_range(40, 22);
            for (int b = 0; b < blocks; b++) begin
                send_block({$urandom, $urandom}, {$urandom, $urandom},
                           (b == blocks - 1) || ($urandom_range(7, 0) == 0), 1'b0, 128'h0);
            end
        end

        wait_idle();
        if (mismatches == 0 && cipher_fifo.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
